// ===== design/pgv_pkg.sv =====
// Package for the paraboloid grid vertex block.
// Holds field widths, register reset values and register index codes.
// No dependencies.
package pgv_pkg;

   // Field widths.
   localparam int GRID_W   = 11;
   localparam int SIZE_W   = 16;
   localparam int RES_W    = 11;
   localparam int CURV_W   = 16;
   localparam int POS_W    = 16;
   localparam int HEIGHT_W = 25;
   localparam int NORM_W   = 16;
   localparam int NORMY_W  = 15;
   localparam int CSR_DW   = 16;

   // Register reset values.
   localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd2560;
   localparam logic [RES_W-1:0]  RES_RESET  = 11'd16;
   localparam logic [CURV_W-1:0] CURV_RESET = 16'd4096;

   // Register index codes.
   typedef enum logic [1:0] {
      CSR_MESH_SIZE  = 2'd0,
      CSR_GRID_RES   = 2'd1,
      CSR_CURVATURE  = 2'd2
   } csr_index_type;

   // Number of iterations of the square root.
   localparam int SQRT_STEPS = 32;

endpackage

// ===== design/pgv_channels.sv =====
// Channel interfaces of the paraboloid grid vertex block: grid point in,
// vertex out and register writes. Depends on pgv_pkg.
interface pgv_req_if;
   import pgv_pkg::*;
   logic              valid;
   logic              ready;
   logic [GRID_W-1:0] grid_row;
   logic [GRID_W-1:0] grid_col;
   modport source (output valid, output grid_row, output grid_col, input ready);
   modport sink   (input valid, input grid_row, input grid_col, output ready);
endinterface

interface pgv_rsp_if;
   import pgv_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [POS_W-1:0]    pos_x;
   logic signed [HEIGHT_W-1:0] pos_y;
   logic signed [POS_W-1:0]    pos_z;
   logic signed [NORM_W-1:0]   norm_x;
   logic [NORMY_W-1:0]         norm_y;
   logic signed [NORM_W-1:0]   norm_z;
   logic                       out_of_range;
   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output norm_x, output norm_y, output norm_z,
                   output out_of_range, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                   input norm_x, input norm_y, input norm_z,
                   input out_of_range, output ready);
endinterface

interface pgv_csr_if;
   import pgv_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        index;
   logic [CSR_DW-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/pgv_divu.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// The quotient must be below 2**Q_W. Carries a sideband alongside.
// No dependencies.
module pgv_divu #(
   parameter int NUM_W  = 27,
   parameter int DEN_W  = 12,
   parameter int Q_W    = 15,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q_W-1:0]    out_quot,
   output logic [SIDE_W-1:0] out_side
);

   localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   logic              valid_ff [Q_W];
   logic [Q_W-1:0]    quot_ff  [Q_W];
   logic [SIDE_W-1:0] side_ff  [Q_W];
   logic [CW-1:0]     rem_ff   [Q_W-1];
   logic [DEN_W-1:0]  den_ff   [Q_W-1];

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      logic              v_prev;
      logic [CW-1:0]     rem_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [Q_W-1:0]    quot_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [CW-1:0]     trial;
      logic [CW-1:0]     rem_in;
      logic [Q_W-1:0]    quot_in;

      // Stage inputs come from the ports or from the stage before.
      if (s == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = CW'(in_num);
         assign den_prev  = in_den;
         assign quot_prev = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = valid_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign den_prev  = den_ff[s-1];
         assign quot_prev = quot_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      // Try to take the shifted divisor off the remainder.
      assign trial = CW'(den_prev) << (Q_W - 1 - s);

      always_comb begin
         rem_in  = rem_prev;
         quot_in = quot_prev;
         if (rem_prev >= trial) begin
            rem_in                = rem_prev - trial;
            quot_in[Q_W - 1 - s] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quot_ff[s] <= quot_in;
            side_ff[s] <= side_prev;
         end
      end

      // The last stage needs no remainder or divisor.
      if (s < Q_W - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= rem_in;
               den_ff[s] <= den_prev;
            end
         end
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_quot  = quot_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

// ===== design/pgv_isqrt.sv =====
// Pipelined bitwise integer square root of a 64-bit value, one iteration
// per stage, with a sideband carried alongside. Depends on pgv_pkg.
module pgv_isqrt #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [63:0]       in_value,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [32:0]       out_root,
   output logic [SIDE_W-1:0] out_side
);
   import pgv_pkg::*;

   logic              valid_ff [SQRT_STEPS];
   logic [63:0]       root_ff  [SQRT_STEPS];
   logic [SIDE_W-1:0] side_ff  [SQRT_STEPS];
   logic [63:0]       rem_ff   [SQRT_STEPS-1];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic              v_prev;
      logic [63:0]       rem_prev;
      logic [63:0]       root_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [63:0]       step_bit;
      logic [64:0]       trial;
      logic [63:0]       rem_in;
      logic [63:0]       root_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = in_value;
         assign root_prev = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = valid_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // One digit of the root per stage.
      assign step_bit = 64'd1 << (62 - 2 * k);
      assign trial    = {1'b0, root_prev} + {1'b0, step_bit};

      always_comb begin
         if ({1'b0, rem_prev} >= trial) begin
            rem_in  = rem_prev - trial[63:0];
            root_in = (root_prev >> 1) + step_bit;
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[k] <= root_in;
            side_ff[k] <= side_prev;
         end
      end

      if (k < SQRT_STEPS - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
            end
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign out_root  = root_ff[SQRT_STEPS-1][32:0];
   assign out_side  = side_ff[SQRT_STEPS-1];

endmodule

// ===== design/paraboloid_grid_vertex.sv =====
// Top level of the paraboloid grid vertex block: registers, position and
// gradient arithmetic, and the output register. Depends on pgv_pkg,
// pgv_channels, pgv_divu and pgv_isqrt.
//
//   Channel   Port      Direction  Carries
//   request   req_bus   in         grid_row, grid_col
//   response  rsp_bus   out        pos_x/y/z, norm_x/y/z, out_of_range
//   config    csr_bus   in         index, data (always ready)
//
// A grid point can be taken every cycle while the pipeline is not held. It
// passes 69 register stages: the input stage, 15 divider stages for the
// position, five arithmetic stages, 32 square root stages, 15 divider stages
// for the normal and the output register.
// Reset clears all valid bits and loads the register reset values.
// The whole pipeline holds while the output register is full and not taken.
module paraboloid_grid_vertex #(
   parameter int RES_MAX = 1024
) (
   input  logic       clock,
   input  logic       reset,
   pgv_req_if.sink    req_bus,
   pgv_rsp_if.source  rsp_bus,
   pgv_csr_if.sink    csr_bus
);
   import pgv_pkg::*;

   localparam int SQ_SIDE_W = 2 * POS_W + HEIGHT_W + 1 + 2 * 33;
   localparam int NY_SIDE_W = 2 * POS_W + HEIGHT_W + 1;

   // Configuration registers.
   logic [SIZE_W-1:0] size_ff;
   logic [RES_W-1:0]  res_ff;
   logic [CURV_W-1:0] curv_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         res_ff  <= RES_RESET;
         curv_ff <= CURV_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_MESH_SIZE: size_ff <= csr_bus.data;
            CSR_GRID_RES:  res_ff  <= csr_bus.data[RES_W-1:0];
            CSR_CURVATURE: curv_ff <= csr_bus.data;
            default:       ;
         endcase
      end
   end

   // Effective resolution, held between one and the maximum.
   logic [RES_W-1:0] res_eff;
   always_comb begin
      if (res_ff == '0) begin
         res_eff = RES_W'(1);
      end else if (32'(res_ff) > 32'(RES_MAX)) begin
         res_eff = RES_W'(RES_MAX);
      end else begin
         res_eff = res_ff;
      end
   end

   // Pipeline advances whenever the output register can take a transfer.
   logic en;
   logic rsp_valid_ff;
   assign en            = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   // Stage A: numerators size*(2*idx - res) as sign and magnitude.
   logic signed [12:0] dx, dz;
   logic signed [29:0] px, pz;
   logic [29:0]        ax, az;
   logic               a_valid_ff, a_oor_ff, a_neg_x_ff, a_neg_z_ff;
   logic [26:0]        a_mag_x_ff, a_mag_z_ff;

   assign dx = $signed({1'b0, req_bus.grid_col, 1'b0}) - $signed({2'b0, res_eff});
   assign dz = $signed({1'b0, req_bus.grid_row, 1'b0}) - $signed({2'b0, res_eff});
   assign px = 30'($signed({1'b0, size_ff}) * dx);
   assign pz = 30'($signed({1'b0, size_ff}) * dz);
   assign ax = px[29] ? 30'(-px) : 30'(px);
   assign az = pz[29] ? 30'(-pz) : 30'(pz);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_mag_x_ff <= ax[26:0];
         a_mag_z_ff <= az[26:0];
         a_neg_x_ff <= px[29];
         a_neg_z_ff <= pz[29];
         a_oor_ff   <= (req_bus.grid_row > res_eff) || (req_bus.grid_col > res_eff);
      end
   end

   // Divide by twice the resolution.
   logic        qx_valid;
   logic [14:0] qx, qz;
   logic [1:0]  qx_side;
   logic        qz_side;

   pgv_divu #(.NUM_W(27), .DEN_W(12), .Q_W(15), .SIDE_W(2)) u_div_x (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(a_valid_ff), .in_num(a_mag_x_ff), .in_den({res_eff, 1'b0}),
      .in_side({a_neg_x_ff, a_oor_ff}),
      .out_valid(qx_valid), .out_quot(qx), .out_side(qx_side)
   );

   pgv_divu #(.NUM_W(27), .DEN_W(12), .Q_W(15), .SIDE_W(1)) u_div_z (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(a_valid_ff), .in_num(a_mag_z_ff), .in_den({res_eff, 1'b0}),
      .in_side(a_neg_z_ff),
      .out_valid(), .out_quot(qz), .out_side(qz_side)
   );

   // Stage B: signed coordinates.
   logic                    b_valid_ff, b_oor_ff;
   logic signed [POS_W-1:0] b_x_ff, b_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= qx_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_x_ff   <= qx_side[1] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
         b_z_ff   <= qz_side ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
         b_oor_ff <= qx_side[0];
      end
   end

   // Stage C: squares and gradients 2*a*x, 2*a*z.
   logic                    c_valid_ff, c_oor_ff;
   logic signed [POS_W-1:0] c_x_ff, c_z_ff;
   logic [31:0]             c_sqx_ff, c_sqz_ff;
   logic signed [32:0]      c_gx_ff, c_gz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_x_ff   <= b_x_ff;
         c_z_ff   <= b_z_ff;
         c_oor_ff <= b_oor_ff;
         c_sqx_ff <= 32'(b_x_ff * b_x_ff);
         c_sqz_ff <= 32'(b_z_ff * b_z_ff);
         c_gx_ff  <= 33'($signed(curv_ff) * b_x_ff) <<< 1;
         c_gz_ff  <= 33'($signed(curv_ff) * b_z_ff) <<< 1;
      end
   end

   // Stage D: sum of squares and gradient magnitudes.
   logic                    d_valid_ff, d_oor_ff, d_neg_gx_ff, d_neg_gz_ff;
   logic signed [POS_W-1:0] d_x_ff, d_z_ff;
   logic [32:0]             d_s_ff, d_abs_gx_ff, d_abs_gz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_x_ff      <= c_x_ff;
         d_z_ff      <= c_z_ff;
         d_oor_ff    <= c_oor_ff;
         d_s_ff      <= {1'b0, c_sqx_ff} + {1'b0, c_sqz_ff};
         d_abs_gx_ff <= c_gx_ff[32] ? 33'(-c_gx_ff) : 33'(c_gx_ff);
         d_abs_gz_ff <= c_gz_ff[32] ? 33'(-c_gz_ff) : 33'(c_gz_ff);
         d_neg_gx_ff <= c_gx_ff[32];
         d_neg_gz_ff <= c_gz_ff[32];
      end
   end

   // Stage E: height product and squared gradients.
   logic                    e_valid_ff, e_oor_ff, e_neg_gx_ff, e_neg_gz_ff;
   logic signed [POS_W-1:0] e_x_ff, e_z_ff;
   logic signed [48:0]      e_prod_ff;
   logic [63:0]             e_gx2_ff, e_gz2_ff;
   logic [32:0]             e_abs_gx_ff, e_abs_gz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_x_ff      <= d_x_ff;
         e_z_ff      <= d_z_ff;
         e_oor_ff    <= d_oor_ff;
         e_prod_ff   <= $signed(curv_ff) * $signed(d_s_ff);
         e_gx2_ff    <= 64'(d_abs_gx_ff[31:0] * d_abs_gx_ff[31:0]);
         e_gz2_ff    <= 64'(d_abs_gz_ff[31:0] * d_abs_gz_ff[31:0]);
         e_abs_gx_ff <= d_abs_gx_ff;
         e_abs_gz_ff <= d_abs_gz_ff;
         e_neg_gx_ff <= d_neg_gx_ff;
         e_neg_gz_ff <= d_neg_gz_ff;
      end
   end

   // Stage F: height scaled to Q16.8 and saturated; square root operand.
   logic [48:0]                prod_mag;
   logic [28:0]                y_mag;
   logic signed [HEIGHT_W-1:0] y_sat;
   logic                       f_valid_ff;
   logic [63:0]                f_sq_ff;
   logic [SQ_SIDE_W-1:0]       f_side_ff;

   assign prod_mag = e_prod_ff[48] ? 49'(-e_prod_ff) : 49'(e_prod_ff);
   assign y_mag    = prod_mag[48:20];

   always_comb begin
      if (!e_prod_ff[48]) begin
         if (y_mag > 29'd16777215) begin
            y_sat = 25'sd16777215;
         end else begin
            y_sat = $signed(y_mag[24:0]);
         end
      end else begin
         if (y_mag > 29'd16777216) begin
            y_sat = $signed({1'b1, 24'd0});
         end else begin
            y_sat = $signed(25'(-y_mag));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_sq_ff   <= e_gx2_ff + e_gz2_ff + (64'd1 << 40);
         f_side_ff <= {e_x_ff, e_z_ff, y_sat, e_oor_ff,
                       e_abs_gx_ff[31:0], e_neg_gx_ff, e_abs_gz_ff[31:0], e_neg_gz_ff};
      end
   end

   // Length of the unnormalised normal.
   logic                 s_valid;
   logic [32:0]          s_len;
   logic [SQ_SIDE_W-1:0] s_side;

   pgv_isqrt #(.SIDE_W(SQ_SIDE_W)) u_isqrt (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(f_valid_ff), .in_value(f_sq_ff), .in_side(f_side_ff),
      .out_valid(s_valid), .out_root(s_len), .out_side(s_side)
   );

   // Unpack the sideband: x, z, y, flag, |gx|, gx sign, |gz|, gz sign.
   logic [NY_SIDE_W-1:0] s_pos;
   logic [31:0]          s_abs_gx, s_abs_gz;
   logic                 s_neg_gx, s_neg_gz;

   assign {s_pos, s_abs_gx, s_neg_gx, s_abs_gz, s_neg_gz} = s_side;

   // Normal components: g * 2^14 / len and 2^34 / len.
   logic                 n_valid;
   logic [14:0]          nqx, nqy, nqz;
   logic                 n_neg_gx, n_neg_gz;
   logic [NY_SIDE_W-1:0] n_pos;

   pgv_divu #(.NUM_W(46), .DEN_W(33), .Q_W(15), .SIDE_W(1)) u_div_nx (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s_valid), .in_num({s_abs_gx, 14'd0}), .in_den(s_len),
      .in_side(s_neg_gx),
      .out_valid(), .out_quot(nqx), .out_side(n_neg_gx)
   );

   pgv_divu #(.NUM_W(46), .DEN_W(33), .Q_W(15), .SIDE_W(1)) u_div_nz (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s_valid), .in_num({s_abs_gz, 14'd0}), .in_den(s_len),
      .in_side(s_neg_gz),
      .out_valid(), .out_quot(nqz), .out_side(n_neg_gz)
   );

   pgv_divu #(.NUM_W(35), .DEN_W(33), .Q_W(15), .SIDE_W(NY_SIDE_W)) u_div_ny (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s_valid), .in_num(35'd1 << 34), .in_den(s_len),
      .in_side(s_pos),
      .out_valid(n_valid), .out_quot(nqy), .out_side(n_pos)
   );

   logic signed [POS_W-1:0]    n_x, n_z;
   logic signed [HEIGHT_W-1:0] n_y;
   logic                       n_oor;

   assign {n_x, n_z, n_y, n_oor} = n_pos;

   // Output register; an out-of-range point gives zeros and the flag.
   logic signed [POS_W-1:0]    rsp_x_ff, rsp_z_ff;
   logic signed [HEIGHT_W-1:0] rsp_y_ff;
   logic signed [NORM_W-1:0]   rsp_nx_ff, rsp_nz_ff;
   logic [NORMY_W-1:0]         rsp_ny_ff;
   logic                       rsp_oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= n_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_oor_ff <= n_oor;
         if (n_oor) begin
            rsp_x_ff  <= '0;
            rsp_y_ff  <= '0;
            rsp_z_ff  <= '0;
            rsp_nx_ff <= '0;
            rsp_ny_ff <= '0;
            rsp_nz_ff <= '0;
         end else begin
            rsp_x_ff  <= n_x;
            rsp_y_ff  <= n_y;
            rsp_z_ff  <= n_z;
            rsp_nx_ff <= n_neg_gx ? $signed({1'b0, nqx}) : -$signed({1'b0, nqx});
            rsp_ny_ff <= nqy;
            rsp_nz_ff <= n_neg_gz ? $signed({1'b0, nqz}) : -$signed({1'b0, nqz});
         end
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.pos_x        = rsp_x_ff;
   assign rsp_bus.pos_y        = rsp_y_ff;
   assign rsp_bus.pos_z        = rsp_z_ff;
   assign rsp_bus.norm_x       = rsp_nx_ff;
   assign rsp_bus.norm_y       = rsp_ny_ff;
   assign rsp_bus.norm_z       = rsp_nz_ff;
   assign rsp_bus.out_of_range = rsp_oor_ff;

   // An out-of-range result carries only zeros.
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_oor_ff |->
         rsp_x_ff == 0 && rsp_y_ff == 0 && rsp_z_ff == 0 &&
         rsp_nx_ff == 0 && rsp_ny_ff == 0 && rsp_nz_ff == 0)
      else $error("out-of-range result with non-zero fields");

   // The vertical normal component is positive and at most one.
   a_ny_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_oor_ff |-> rsp_ny_ff != 0 && rsp_ny_ff <= 15'd16384)
      else $error("norm_y outside its range");

   // Horizontal normal components stay within plus or minus one.
   a_nxz_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         rsp_nx_ff >= -16'sd16384 && rsp_nx_ff <= 16'sd16384 &&
         rsp_nz_ff >= -16'sd16384 && rsp_nz_ff <= 16'sd16384)
      else $error("horizontal normal component outside its range");

endmodule
